// ----- hw/rtl/dms_pkg.sv -----
// ----------------------------------------------------------------------------
// dms_pkg: shared constants and a helper for the descriptor medoid selector
// Word layout of a descriptor, result field widths and a 64-bit popcount.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

  // Width of one descriptor word on the input channel.
  localparam int WordW = 64;
  // Words carried by one input item.
  localparam int InWords = 4;
  // Result field widths.
  localparam int IndexW = 6;
  localparam int MedianW = 9;

  // Count the set bits of one word with a short adder tree.
  function automatic logic [6:0] popcount64(input logic [WordW-1:0] x);
    logic [WordW-1:0] s1;
    logic [WordW-1:0] s2;
    logic [WordW-1:0] s3;
    logic [WordW-1:0] s4;
    logic [WordW-1:0] s5;
    logic [WordW-1:0] s6;
    s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
    s3 = (s2 + (s2 >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    s4 = s3 + (s3 >> 8);
    s5 = s4 + (s4 >> 16);
    s6 = s5 + (s5 >> 32);
    return s6[6:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/descriptor_medoid_select.sv -----
// ----------------------------------------------------------------------------
// descriptor_medoid_select: medoid pick over binary descriptors
// Stores a set of descriptors, then returns the one whose median Hamming
// distance to the rest of the set is smallest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) transfers one descriptor per
//   item. Items with source_is_bad_i set are not stored; good items beyond
//   MAX_DESCRIPTORS are dropped and raise the overflow flag. An item with
//   last_item_i set closes the set and starts the computation.
//   Output channel (out_valid_o / out_stall_i) transfers one result per set.
//   Items are loaded back to back while the block is idle. After the last
//   item, each of the N stored rows is loaded and compared with every stored
//   row, one 64-bit word at a time, and each distance is counted into a
//   histogram of B = 64*W+1 bins, where W is the number of 64-bit words in
//   use (W = 4, B = 257 at the defaults); the histogram is then swept to find
//   the row's median and clear its bins. A final step moves the result to the
//   output register. The speed is set by the single popcount unit, one word
//   per cycle, and by the per-row histogram sweep through its memory.
//   After reset the histogram memory is cleared with in_stall_o high. A
//   stalled result holds in the output register; new items are still taken,
//   and the next result waits for it.
`default_nettype none

module descriptor_medoid_select
  import dms_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = 64,
  parameter int DESCRIPTOR_BITS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [WordW-1:0]    desc_word0_i,
  input  wire logic [WordW-1:0]    desc_word1_i,
  input  wire logic [WordW-1:0]    desc_word2_i,
  input  wire logic [WordW-1:0]    desc_word3_i,
  input  wire logic                source_is_bad_i,
  input  wire logic                last_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     found_o,
  output logic [IndexW-1:0]        best_index_o,
  output logic [MedianW-1:0]       best_median_o,
  output logic                     overflowed_o
);

  // Words that take part in the distance, at most the four carried in.
  localparam int WordsRaw = DESCRIPTOR_BITS / WordW;
  localparam int Words    = (WordsRaw > InWords) ? InWords : WordsRaw;
  localparam int StoreW   = Words * WordW;
  localparam int WIdxW    = (Words > 1) ? $clog2(Words) : 1;
  // Index and count widths for the descriptor store.
  localparam int IdxW     = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int CntW     = $clog2(MAX_DESCRIPTORS + 1);
  // One histogram bin per possible distance, 0 through StoreW.
  localparam int NumBins  = StoreW + 1;
  localparam int BinW     = $clog2(NumBins);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ROW_LD  = 4'd2;
  localparam logic [3:0] S_ROW_CAP = 4'd3;
  localparam logic [3:0] S_J_RD    = 4'd4;
  localparam logic [3:0] S_POP     = 4'd5;
  localparam logic [3:0] S_H_RD    = 4'd6;
  localparam logic [3:0] S_H_WR    = 4'd7;
  localparam logic [3:0] S_SC_RD   = 4'd8;
  localparam logic [3:0] S_SC_CHK  = 4'd9;
  localparam logic [3:0] S_ROW_END = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  // Control state.
  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            out_vld_q, out_vld_d;
  logic [BinW-1:0] bin_q, bin_d;

  // Working registers.
  logic [IdxW-1:0]    row_i_q, row_i_d;
  logic [IdxW-1:0]    col_j_q, col_j_d;
  logic [WIdxW-1:0]   word_q, word_d;
  logic [BinW-1:0]    acc_q, acc_d;
  logic [CntW-1:0]    cum_q, cum_d;
  logic [BinW-1:0]    med_q, med_d;
  logic               med_hit_q, med_hit_d;
  logic               have_q, have_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [BinW-1:0]    best_med_q, best_med_d;
  logic [StoreW-1:0]  row_q, row_d;
  logic               res_found_q, res_found_d;
  logic [IndexW-1:0]  res_idx_q, res_idx_d;
  logic [MedianW-1:0] res_med_q, res_med_d;
  logic               res_ovf_q, res_ovf_d;

  // Descriptor store: written at the fill count, read at one address.
  logic [StoreW-1:0] store_mem [MAX_DESCRIPTORS];
  logic [StoreW-1:0] st_rd_q;
  logic              st_we;
  logic [IdxW-1:0]   st_raddr;
  logic [StoreW-1:0] st_wdata;

  // Per-row distance histogram.
  logic [CntW-1:0] hist_mem [NumBins];
  logic [CntW-1:0] h_rd_q;
  logic            h_we;
  logic [BinW-1:0] h_waddr;
  logic [BinW-1:0] h_raddr;
  logic [CntW-1:0] h_wdata;

  logic [InWords*WordW-1:0] in_words;
  logic                     accept;
  logic                     full;
  logic                     keep;
  logic [6:0]               pc;
  logic [CntW-1:0]          kth;
  logic [CntW-1:0]          cum_sum;
  logic                     last_col;
  logic                     last_row;

  assign in_words = {desc_word3_i, desc_word2_i, desc_word1_i, desc_word0_i};
  assign st_wdata = in_words[StoreW-1:0];
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign full     = (cnt_q == CntW'(MAX_DESCRIPTORS));
  assign keep     = !source_is_bad_i && !full;
  // Shared unit: one word of xor-popcount per cycle.
  assign pc       = popcount64(row_q[word_q*WordW +: WordW] ^
                               st_rd_q[word_q*WordW +: WordW]);
  // Median sits at sorted position floor((N-1)/2).
  assign kth      = (cnt_q - CntW'(1)) >> 1;
  assign cum_sum  = cum_q + h_rd_q;
  assign last_col = ((CntW'(col_j_q) + CntW'(1)) == cnt_q);
  assign last_row = ((CntW'(row_i_q) + CntW'(1)) == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_vld_d   = out_vld_q && out_stall_i;
    bin_d       = bin_q;
    row_i_d     = row_i_q;
    col_j_d     = col_j_q;
    word_d      = word_q;
    acc_d       = acc_q;
    cum_d       = cum_q;
    med_d       = med_q;
    med_hit_d   = med_hit_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_med_d  = best_med_q;
    row_d       = row_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    res_med_d   = res_med_q;
    res_ovf_d   = res_ovf_q;
    st_we       = 1'b0;
    st_raddr    = col_j_q;
    h_we        = 1'b0;
    h_waddr     = bin_q;
    h_raddr     = bin_q;
    h_wdata     = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Zero every bin once after reset.
        h_we = 1'b1;
        if (bin_q == BinW'(NumBins - 1)) begin
          state_d = S_IDLE;
        end else begin
          bin_d = bin_q + BinW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          st_we = keep;
          cnt_d = cnt_q + CntW'(keep);
          if (!source_is_bad_i && full) begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            have_d     = 1'b0;
            best_idx_d = '0;
            best_med_d = '0;
            row_i_d    = '0;
            state_d    = (cnt_d == '0) ? S_FIN : S_ROW_LD;
          end
        end
      end
      S_ROW_LD: begin
        st_raddr = row_i_q;
        state_d  = S_ROW_CAP;
      end
      S_ROW_CAP: begin
        row_d   = st_rd_q;
        col_j_d = '0;
        state_d = S_J_RD;
      end
      S_J_RD: begin
        word_d  = '0;
        acc_d   = '0;
        state_d = S_POP;
      end
      S_POP: begin
        acc_d  = acc_q + BinW'(pc);
        word_d = word_q + WIdxW'(1);
        if (word_q == WIdxW'(Words - 1)) begin
          state_d = S_H_RD;
        end
      end
      S_H_RD: begin
        h_raddr = acc_q;
        state_d = S_H_WR;
      end
      S_H_WR: begin
        h_we    = 1'b1;
        h_waddr = acc_q;
        h_wdata = h_rd_q + CntW'(1);
        if (last_col) begin
          bin_d     = '0;
          cum_d     = '0;
          med_hit_d = 1'b0;
          state_d   = S_SC_RD;
        end else begin
          col_j_d = col_j_q + IdxW'(1);
          state_d = S_J_RD;
        end
      end
      S_SC_RD: begin
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        // Accumulate, drop the bin back to zero, catch the median bin.
        h_we  = 1'b1;
        cum_d = cum_sum;
        if (!med_hit_q && (cum_sum > kth)) begin
          med_d     = bin_q;
          med_hit_d = 1'b1;
        end
        if (bin_q == BinW'(NumBins - 1)) begin
          state_d = S_ROW_END;
        end else begin
          bin_d   = bin_q + BinW'(1);
          state_d = S_SC_RD;
        end
      end
      S_ROW_END: begin
        if (!have_q || (med_q < best_med_q)) begin
          have_d     = 1'b1;
          best_med_d = med_q;
          best_idx_d = row_i_q;
        end
        if (last_row) begin
          state_d = S_FIN;
        end else begin
          row_i_d = row_i_q + IdxW'(1);
          state_d = S_ROW_LD;
        end
      end
      S_FIN: begin
        // Wait for the output register to free up, then start a new set.
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d   = 1'b1;
          res_found_d = have_q;
          res_idx_d   = IndexW'(best_idx_q);
          res_med_d   = MedianW'(best_med_q);
          res_ovf_d   = ovf_q;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
      bin_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
      bin_q     <= bin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_i_q     <= row_i_d;
    col_j_q     <= col_j_d;
    word_q      <= word_d;
    acc_q       <= acc_d;
    cum_q       <= cum_d;
    med_q       <= med_d;
    med_hit_q   <= med_hit_d;
    have_q      <= have_d;
    best_idx_q  <= best_idx_d;
    best_med_q  <= best_med_d;
    row_q       <= row_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    res_med_q   <= res_med_d;
    res_ovf_q   <= res_ovf_d;
  end

  // Descriptor store.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[cnt_q[IdxW-1:0]] <= st_wdata;
    end
    st_rd_q <= store_mem[st_raddr];
  end

  // Histogram memory.
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_waddr] <= h_wdata;
    end
    h_rd_q <= hist_mem[h_raddr];
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_vld_q;
  assign found_o       = res_found_q;
  assign best_index_o  = res_idx_q;
  assign best_median_o = res_med_q;
  assign overflowed_o  = res_ovf_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DESCRIPTORS))
    else $error("stored count beyond store depth");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the finish step");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_index_o == '0 && best_median_o == '0))
    else $error("empty set result carries nonzero fields");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_J_RD) |-> (CntW'(col_j_q) < cnt_q))
    else $error("column index past stored count");
`endif

endmodule

`default_nettype wire

// ----- dv/descriptor_medoid_select_tb.sv -----
// ----------------------------------------------------------------------------
// descriptor_medoid_select_tb: self-checking bench for the medoid selector
// Streams sets of 256-bit descriptors (directed corner sets, one store-full
// set, then random sets of varied content) under three idle/stall mixes. A built-in
// model tracks the stored set and predicts each result. The result checker
// compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module descriptor_medoid_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dms_pkg::*;

  localparam int MAX_DESCRIPTORS = 64;
  localparam int DESCRIPTOR_BITS = 256;
  localparam int DescBits = InWords * WordW;
  // Words that take part in the distance, capped by what an item carries.
  localparam int UsedWords = (DESCRIPTOR_BITS / WordW > InWords) ? InWords :
                             (DESCRIPTOR_BITS / WordW < 1) ? 1 : DESCRIPTOR_BITS / WordW;
  localparam logic [DescBits-1:0] UsedMask = {DescBits{1'b1}} >> (DescBits - UsedWords * WordW);
  // A full set of 64 is computed with no transfer at all; the limit covers
  // that, the clearing pass and the stall tail, then several times over.
  localparam int StallLimit = 250_000;
  localparam int TailCycles = 2_000;

  typedef struct packed {
    logic               found;
    logic [IndexW-1:0]  best_index;
    logic [MedianW-1:0] best_median;
    logic               overflowed;
  } medoid_result_t;

  // Content patterns for random sets.
  typedef enum int {
    PatRandom,   // independent random descriptors, distances near half
    PatCluster,  // one base with sparse flips, small and varied distances
    PatProtos    // a few prototypes, many duplicates and ties
  } set_pattern_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [WordW-1:0]    desc_word0_i;
  logic [WordW-1:0]    desc_word1_i;
  logic [WordW-1:0]    desc_word2_i;
  logic [WordW-1:0]    desc_word3_i;
  logic                source_is_bad_i;
  logic                last_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                found_o;
  logic [IndexW-1:0]   best_index_o;
  logic [MedianW-1:0]  best_median_o;
  logic                overflowed_o;

  // Model state: the descriptors of the open set and its overflow flag.
  logic [DescBits-1:0] held_descs [MAX_DESCRIPTORS];
  int                  held_count = 0;
  logic                held_overflow = 1'b0;
  medoid_result_t      expected_medoids [$];

  int tx_idle_pct = 16;
  int rx_idle_pct = 67;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  descriptor_medoid_select #(
    .MAX_DESCRIPTORS(MAX_DESCRIPTORS),
    .DESCRIPTOR_BITS(DESCRIPTOR_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .desc_word0_i   (desc_word0_i),
    .desc_word1_i   (desc_word1_i),
    .desc_word2_i   (desc_word2_i),
    .desc_word3_i   (desc_word3_i),
    .source_is_bad_i(source_is_bad_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .best_index_o   (best_index_o),
    .best_median_o  (best_median_o),
    .overflowed_o   (overflowed_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Medoid model
  // --------------------------------------------------------------------------

  // Pick the descriptor whose sorted distance row has the smallest value at
  // position floor((N-1)/2); the row holds its own zero distance. Strict
  // less-than keeps the earliest index on a tie.
  function automatic medoid_result_t pick_medoid();
    medoid_result_t res;
    int             row [MAX_DESCRIPTORS];
    int             i, j, k, v, med;
    bit             have;
    res  = '0;
    have = 1'b0;
    for (i = 0; i < held_count; i++) begin
      for (j = 0; j < held_count; j++) begin
        row[j] = (i == j) ? 0 : $countones((held_descs[i] ^ held_descs[j]) & UsedMask);
      end
      for (j = 1; j < held_count; j++) begin
        v = row[j];
        k = j;
        while (k > 0 && row[k-1] > v) begin
          row[k] = row[k-1];
          k--;
        end
        row[k] = v;
      end
      med = row[(held_count - 1) / 2];
      if (!have || med < res.best_median) begin
        have            = 1'b1;
        res.best_median = med[MedianW-1:0];
        res.best_index  = i[IndexW-1:0];
      end
    end
    // An empty set reports found=0 with index and median at zero.
    res.found      = have;
    res.overflowed = held_overflow;
    return res;
  endfunction

  // Advance the model by one accepted transfer.
  task automatic absorb_item(input logic [DescBits-1:0] d, input logic bad, input logic last);
    if (!bad) begin
      if (held_count < MAX_DESCRIPTORS) begin
        held_descs[held_count] = d;
        held_count++;
      end else begin
        // Store full: drop the descriptor, remember the loss.
        held_overflow = 1'b1;
      end
    end
    // A bad item that closes the set still triggers the computation.
    if (last) begin
      expected_medoids = {expected_medoids, pick_medoid()};
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [DescBits-1:0] rand_desc();
    logic [DescBits-1:0] v;
    for (int i = 0; i < DescBits / 32; i++) v[i*32 +: 32] = $urandom();
    return v;
  endfunction

  // Sparse flip mask, density from 1/4 down to 1/32.
  function automatic logic [DescBits-1:0] sparse_mask();
    logic [DescBits-1:0] v;
    v = rand_desc();
    repeat ($urandom_range(1, 4)) v &= rand_desc();
    return v;
  endfunction

  // Drive one item and hold it until the block takes it. Valid is lowered
  // only for an idle gap, so it never gets two updates in one step.
  task automatic send_desc(input logic [DescBits-1:0] d, input logic bad, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    desc_word0_i    <= d[0*WordW +: WordW];
    desc_word1_i    <= d[1*WordW +: WordW];
    desc_word2_i    <= d[2*WordW +: WordW];
    desc_word3_i    <= d[3*WordW +: WordW];
    source_is_bad_i <= bad;
    last_item_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_item(d, bad, last);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty set: only bad items, the last one closes the set.
  task automatic test_empty_set();
    send_desc(rand_desc(), 1'b1, 1'b0);
    send_desc(rand_desc(), 1'b1, 1'b1);
  endtask

  // One descriptor: found, index zero, median zero.
  task automatic test_single_descriptor();
    send_desc({DescBits{1'b1}}, 1'b0, 1'b1);
  endtask

  // All-zero, all-one and alternating words: distances of 0, 128 and 256.
  task automatic test_extreme_words();
    send_desc({DescBits{1'b0}}, 1'b0, 1'b0);
    send_desc({DescBits{1'b1}}, 1'b0, 1'b0);
    send_desc({(DescBits/4){4'h5}}, 1'b0, 1'b0);
    send_desc({(DescBits/4){4'ha}}, 1'b0, 1'b1);
  endtask

  // A bad item closes the set; it is not stored but the result comes.
  task automatic test_bad_last_item();
    repeat (3) send_desc(rand_desc(), 1'b0, 1'b0);
    send_desc({DescBits{1'b1}}, 1'b1, 1'b1);
  endtask

  // Two equal best medians; the earliest index wins. A bad item in the
  // middle must not take an index.
  task automatic test_tie_earliest();
    send_desc({DescBits{1'b1}}, 1'b0, 1'b0);
    send_desc({DescBits{1'b0}}, 1'b0, 1'b0);
    send_desc(rand_desc(), 1'b1, 1'b0);
    send_desc({DescBits{1'b0}}, 1'b0, 1'b0);
    send_desc({1'b1, {(DescBits-1){1'b0}}}, 1'b0, 1'b1);
  endtask

  // Fill the store, drop two more (the closing one too), then check that
  // the flag clears for the next set.
  task automatic test_store_full();
    logic [DescBits-1:0] base;
    base = rand_desc();
    repeat (MAX_DESCRIPTORS + 1) send_desc(base ^ sparse_mask(), 1'b0, 1'b0);
    send_desc(rand_desc(), 1'b0, 1'b1);
    send_desc(rand_desc(), 1'b0, 1'b0);
    send_desc(rand_desc(), 1'b0, 1'b1);
  endtask

  // Random sets, mostly small. Bad items are noise and are not counted.
  task automatic test_random_sets(input int tx_pct, input int rx_pct, input int target);
    int                  sent, size, r, k;
    set_pattern_e        pattern;
    logic [DescBits-1:0] protos [3];
    logic [DescBits-1:0] d;
    bit                  bad_close;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent        = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 5) size = 0;
      else if (r < 85) size = $urandom_range(1, 8);
      else size = $urandom_range(9, 20);
      pattern = set_pattern_e'($urandom_range(0, 2));
      for (k = 0; k < 3; k++) protos[k] = rand_desc();
      bad_close = (size == 0) || ($urandom_range(0, 99) < 15);
      for (k = 0; k < size; k++) begin
        if ($urandom_range(0, 99) < 12) send_desc(rand_desc(), 1'b1, 1'b0);
        case (pattern)
          PatRandom: begin
            d = rand_desc();
          end
          PatCluster: begin
            d = protos[0] ^ sparse_mask();
          end
          default: begin
            d = protos[$urandom_range(0, 2)];
            if ($urandom_range(0, 3) == 0) d ^= sparse_mask();
          end
        endcase
        send_desc(d, 1'b0, (k == size - 1) && !bad_close);
        sent++;
      end
      if (bad_close) send_desc(rand_desc(), 1'b1, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Randomize the receiver stall; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  task automatic compare_field(input string field, input int want, input logic [15:0] got);
    if (got !== want[15:0]) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    medoid_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medoids.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b index=%0d median=%0d",
                 $time, found_o, best_index_o, best_median_o);
        mismatch_count++;
      end else begin
        want = expected_medoids.pop_front();
        compare_field("found", int'(want.found), 16'(found_o));
        compare_field("best_index", int'(want.best_index), 16'(best_index_o));
        compare_field("best_median", int'(want.best_median), 16'(best_median_o));
        compare_field("overflowed", int'(want.overflowed), 16'(overflowed_o));
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    desc_word0_i    <= '0;
    desc_word1_i    <= '0;
    desc_word2_i    <= '0;
    desc_word3_i    <= '0;
    source_is_bad_i <= 1'b0;
    last_item_i     <= 1'b0;
    out_stall_i     <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The sender waits out the clearing pass through the handshake.
    test_empty_set();
    test_single_descriptor();
    test_extreme_words();
    test_bad_last_item();
    test_tie_earliest();
    test_store_full();
    test_random_sets(16, 67, 150);
    test_random_sets(67, 16, 150);
    test_random_sets(0, 0, 150);

    in_valid_i <= 1'b0;
    while (expected_medoids.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
